// ----- src/edfs_pkg.sv -----
// Package for the earliest-deadline-first unit task scheduler.
// Holds the job entry type, the outcome codes and the controller/datapath
// command and status structs; no dependencies.
`default_nettype none

package edfs_pkg;

    localparam int REL_W     = 8;
    localparam int DL_W      = 8;
    localparam int UNITS_W   = 7;
    localparam int DAY_OUT_W = 8;
    localparam int IDX_OUT_W = 7;
    localparam int OUTC_W    = 2;

    localparam logic [OUTC_W-1:0] OUTCOME_IDLE     = 2'd0;
    localparam logic [OUTC_W-1:0] OUTCOME_GIVEN    = 2'd1;
    localparam logic [OUTC_W-1:0] OUTCOME_DEADLINE = 2'd2;
    localparam logic [OUTC_W-1:0] OUTCOME_FAILED   = 2'd3;

    typedef struct packed {
        logic [UNITS_W-1:0] units;
        logic [DL_W-1:0]    dl_day;
        logic [REL_W-1:0]   rel_day;
    } job_entry_t;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic scan_en;
        logic decide;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_short;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/edf_unit_task_scheduler_core.sv -----
// Top level of the earliest-deadline-first unit task scheduler.
// A load beat leaves the controller in IDLE, ready for the next beat. A tick beat passes
// through the scan, decision and emit states, the scan reading one job entry per cycle;
// the emit state waits while the output still holds a result that was not taken. A tick
// on a failed or exhausted schedule skips scan and decision. Reset clears the job count,
// day and failure flag; the job RAM is not cleared. Depends on edfs_pkg, edfs_ctrl,
// edfs_datapath and edfs_ram.
`default_nettype none

module edf_unit_task_scheduler_core #(
    parameter int MAX_JOBS = 64,
    parameter int MAX_DAYS = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // release_day, deadline_day, work_units, zero pad
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // day_number, job_index, zero pad
    output logic [1:0]       m_tuser    // outcome
);

    edfs_pkg::ctrl_cmd_t  cmd;
    edfs_pkg::dp_status_t status;
    edfs_pkg::job_entry_t load_entry;

    logic [edfs_pkg::DAY_OUT_W-1:0] m_day;
    logic [edfs_pkg::IDX_OUT_W-1:0] m_job_index;

    assign load_entry.rel_day = s_tdata[7:0];
    assign load_entry.dl_day  = s_tdata[15:8];
    assign load_entry.units   = s_tdata[22:16];

    edfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    edfs_datapath #(
        .MAX_JOBS(MAX_JOBS),
        .MAX_DAYS(MAX_DAYS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .load_entry  (load_entry),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_day       (m_day),
        .m_outcome   (m_tuser),
        .m_job_index (m_job_index)
    );

    assign m_tdata = {1'b0, m_job_index, m_day};

endmodule

`default_nettype wire

// ----- src/edfs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module edfs_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/edfs_ctrl.sv -----
// Controller state machine of the scheduler: sequences load, scan,
// decision and result beats. Depends on edfs_pkg.
`default_nettype none

module edfs_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tuser,
    output logic                       s_tready,
    input  wire edfs_pkg::dp_status_t  status,
    output edfs_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        cmd.tick_start = 1'b1;
                        state_next     = status.tick_short ? ST_EMIT : ST_SCAN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/edfs_datapath.sv -----
// Datapath of the scheduler: job store, day counter, minimum-deadline scan
// accumulators and the output register. Depends on edfs_pkg and edfs_ram.
`default_nettype none

module edfs_datapath #(
    parameter int MAX_JOBS = 64,
    parameter int MAX_DAYS = 128
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire edfs_pkg::ctrl_cmd_t                   cmd,
    output edfs_pkg::dp_status_t                       status,
    input  wire edfs_pkg::job_entry_t                  load_entry,
    input  wire logic                                  m_tready,
    output logic                                       m_tvalid,
    output logic [edfs_pkg::DAY_OUT_W-1:0]             m_day,
    output logic [edfs_pkg::OUTC_W-1:0]                m_outcome,
    output logic [edfs_pkg::IDX_OUT_W-1:0]             m_job_index
);

    localparam int IW   = $clog2(MAX_JOBS);
    localparam int CW   = $clog2(MAX_JOBS + 1);
    localparam int DW   = $clog2(MAX_DAYS + 1);
    localparam int CMPW = (DW > 8) ? DW : 8;
    localparam int EW   = $bits(edfs_pkg::job_entry_t);

    logic [CW-1:0] count_reg, count_next;
    logic [DW-1:0] day_reg, day_next;
    logic          failed_reg, failed_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          rd_valid_reg;
    logic [IW-1:0] rd_idx_reg;

    logic                 best_valid_reg, best_valid_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    edfs_pkg::job_entry_t best_entry_reg, best_entry_next;
    logic                 due_any_valid_reg, due_any_valid_next;
    logic [IW-1:0]        due_any_idx_reg, due_any_idx_next;
    logic                 due_left_valid_reg, due_left_valid_next;
    logic [IW-1:0]        due_left_idx_reg, due_left_idx_next;

    logic [edfs_pkg::DAY_OUT_W-1:0] res_day_reg, res_day_next;
    logic [edfs_pkg::OUTC_W-1:0]    res_outcome_reg, res_outcome_next;
    logic [edfs_pkg::IDX_OUT_W-1:0] res_idx_reg, res_idx_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [edfs_pkg::DAY_OUT_W-1:0] m_day_reg;
    logic [edfs_pkg::OUTC_W-1:0]    m_outcome_reg;
    logic [edfs_pkg::IDX_OUT_W-1:0] m_idx_reg;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    edfs_pkg::job_entry_t ram_wdata;
    logic                 ram_re;
    logic [EW-1:0]        ram_rdata_raw;
    edfs_pkg::job_entry_t rd_entry;

    logic          at_max;
    logic          can_load;
    logic          take_unit;
    logic [DW-1:0] day_inc;
    logic [31:0]   day_inc_w;
    logic [31:0]   day_w;
    logic [31:0]   max_w;
    logic [31:0]   best_num_w;
    logic [31:0]   any_num_w;
    logic [31:0]   left_num_w;
    logic [CMPW-1:0] day_cmp;
    logic [CMPW-1:0] dl_cmp;
    logic [CMPW-1:0] rel_cmp;
    logic [CMPW-1:0] best_dl_cmp;
    logic          is_due;
    logic          is_elig;

    assign rd_entry = edfs_pkg::job_entry_t'(ram_rdata_raw);

    edfs_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_JOBS)
    ) u_job_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (EW'(ram_wdata)),
        .re    (ram_re),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign at_max     = (day_reg >= DW'(MAX_DAYS));
    assign can_load   = (count_reg < CW'(MAX_JOBS));
    assign day_inc    = day_reg + DW'(1);
    assign day_inc_w  = 32'(day_inc);
    assign day_w      = 32'(day_reg);
    assign max_w      = 32'(MAX_DAYS);
    assign best_num_w = 32'(best_idx_reg) + 32'd1;
    assign any_num_w  = 32'(due_any_idx_reg) + 32'd1;
    assign left_num_w = 32'(due_left_idx_reg) + 32'd1;

    assign take_unit = cmd.decide && !due_left_valid_reg && !due_any_valid_reg
                       && best_valid_reg;

    assign ram_re = cmd.scan_en && (ptr_reg < count_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = best_entry_reg;
        if (cmd.load && can_load) begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IW-1:0];
            ram_wdata = load_entry;
        end else if (take_unit) begin
            ram_we          = 1'b1;
            ram_wdata.units = best_entry_reg.units - edfs_pkg::UNITS_W'(1);
        end
    end

    assign day_cmp     = CMPW'(day_reg);
    assign dl_cmp      = CMPW'(rd_entry.dl_day);
    assign rel_cmp     = CMPW'(rd_entry.rel_day);
    assign best_dl_cmp = CMPW'(best_entry_reg.dl_day);
    assign is_due      = (dl_cmp == day_cmp);
    assign is_elig     = (dl_cmp > day_cmp) && (rel_cmp <= day_cmp)
                         && (rd_entry.units != '0);

    assign status.tick_short = at_max || failed_reg;
    assign status.scan_done  = (ptr_reg >= count_reg) && !rd_valid_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        count_next          = count_reg;
        day_next            = day_reg;
        failed_next         = failed_reg;
        ptr_next            = ptr_reg;
        best_valid_next     = best_valid_reg;
        best_idx_next       = best_idx_reg;
        best_entry_next     = best_entry_reg;
        due_any_valid_next  = due_any_valid_reg;
        due_any_idx_next    = due_any_idx_reg;
        due_left_valid_next = due_left_valid_reg;
        due_left_idx_next   = due_left_idx_reg;
        res_day_next        = res_day_reg;
        res_outcome_next    = res_outcome_reg;
        res_idx_next        = res_idx_reg;

        if (cmd.load && can_load) begin
            count_next = count_reg + CW'(1);
        end

        if (cmd.tick_start) begin
            res_outcome_next = failed_reg ? edfs_pkg::OUTCOME_FAILED
                                          : edfs_pkg::OUTCOME_IDLE;
            res_idx_next     = '0;
            if (at_max) begin
                res_day_next = max_w[edfs_pkg::DAY_OUT_W-1:0];
            end else begin
                day_next     = day_inc;
                res_day_next = day_inc_w[edfs_pkg::DAY_OUT_W-1:0];
            end
            ptr_next            = '0;
            best_valid_next     = 1'b0;
            due_any_valid_next  = 1'b0;
            due_left_valid_next = 1'b0;
        end

        if (ram_re) begin
            ptr_next = ptr_reg + CW'(1);
        end

        if (rd_valid_reg) begin
            if (is_due) begin
                if (!due_any_valid_reg) begin
                    due_any_valid_next = 1'b1;
                    due_any_idx_next   = rd_idx_reg;
                end
                if (!due_left_valid_reg && rd_entry.units != '0) begin
                    due_left_valid_next = 1'b1;
                    due_left_idx_next   = rd_idx_reg;
                end
            end else if (is_elig) begin
                if (!best_valid_reg || dl_cmp < best_dl_cmp) begin
                    best_valid_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_entry_next = rd_entry;
                end
            end
        end

        if (cmd.decide) begin
            res_day_next = day_w[edfs_pkg::DAY_OUT_W-1:0];
            if (due_left_valid_reg) begin
                failed_next      = 1'b1;
                res_outcome_next = edfs_pkg::OUTCOME_FAILED;
                res_idx_next     = left_num_w[edfs_pkg::IDX_OUT_W-1:0];
            end else if (due_any_valid_reg) begin
                res_outcome_next = edfs_pkg::OUTCOME_DEADLINE;
                res_idx_next     = any_num_w[edfs_pkg::IDX_OUT_W-1:0];
            end else if (best_valid_reg) begin
                res_outcome_next = edfs_pkg::OUTCOME_GIVEN;
                res_idx_next     = best_num_w[edfs_pkg::IDX_OUT_W-1:0];
            end else begin
                res_outcome_next = edfs_pkg::OUTCOME_IDLE;
                res_idx_next     = '0;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg          <= '0;
            day_reg            <= '0;
            failed_reg         <= 1'b0;
            ptr_reg            <= '0;
            rd_valid_reg       <= 1'b0;
            best_valid_reg     <= 1'b0;
            due_any_valid_reg  <= 1'b0;
            due_left_valid_reg <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            count_reg          <= count_next;
            day_reg            <= day_next;
            failed_reg         <= failed_next;
            ptr_reg            <= ptr_next;
            rd_valid_reg       <= ram_re;
            best_valid_reg     <= best_valid_next;
            due_any_valid_reg  <= due_any_valid_next;
            due_left_valid_reg <= due_left_valid_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg       <= ptr_reg[IW-1:0];
        best_idx_reg     <= best_idx_next;
        best_entry_reg   <= best_entry_next;
        due_any_idx_reg  <= due_any_idx_next;
        due_left_idx_reg <= due_left_idx_next;
        res_day_reg      <= res_day_next;
        res_outcome_reg  <= res_outcome_next;
        res_idx_reg      <= res_idx_next;
        if (cmd.emit) begin
            m_day_reg     <= res_day_reg;
            m_outcome_reg <= res_outcome_reg;
            m_idx_reg     <= res_idx_reg;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_day       = m_day_reg;
    assign m_outcome   = m_outcome_reg;
    assign m_job_index = m_idx_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_JOBS))
        else $error("Job count exceeds capacity.");

    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |=> failed_reg)
        else $error("Failure flag cleared after being set.");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= count_reg)
        else $error("Scan pointer ran past the stored jobs.");

    a_unit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        take_unit |-> (best_entry_reg.units != '0))
        else $error("Work unit given to a finished job.");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid_reg)
        else $error("Result beat not presented after emit.");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for edf_unit_task_scheduler_core: a directed table of job
// loads and day ticks, then random well-formed jobs with noise, checked beat by beat.
// Depends on edfs_pkg and the scheduler RTL; stream traffic with random idling on both sides.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_JOBS   = 64;
    localparam int MAX_DAYS   = 128;
    localparam int ITEMS      = 1300;
    localparam int DRAIN_TAIL = 80;
    localparam int DIR_ROWS   = 20;

    localparam bit REQ_LOAD = 1'b0;
    localparam bit REQ_TICK = 1'b1;

    typedef struct packed {
        logic [7:0] day;
        logic [1:0] outcome;
        logic [6:0] job;
    } day_result_t;

    typedef struct packed {
        bit          req;
        logic [7:0]  rel;
        logic [7:0]  dl;
        logic [6:0]  units;
        bit          typed;
        day_result_t want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [7:0] job_rel  [MAX_JOBS];
    logic [7:0] job_dl   [MAX_JOBS];
    logic [6:0] job_left [MAX_JOBS];
    int         jobs_loaded  = 0;
    int         today        = 0;
    bit         sched_failed = 1'b0;

    day_result_t pending_days[$];
    stim_row_t   dir_rows [DIR_ROWS];
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          error_count = 0;
    int          outcome_seen [4] = '{0, 0, 0, 0};
    logic [6:0]  rx_phase = '0;
    logic [1:0]  rx_mode  = '0;

    edf_unit_task_scheduler_core #(
        .MAX_JOBS(MAX_JOBS),
        .MAX_DAYS(MAX_DAYS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch: %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Loads fill the next job slot; a tick steps the day up to MAX_DAYS, may give one unit.
    function automatic bit schedule_step(input bit req, input logic [7:0] rel,
                                         input logic [7:0] dl, input logic [6:0] units,
                                         output day_result_t res);
        int due_any;
        int due_left;
        int best;
        int k;
        due_any  = -1;
        due_left = -1;
        best     = -1;
        res      = '0;
        if (req == REQ_LOAD) begin
            if (jobs_loaded < MAX_JOBS) begin
                job_rel[jobs_loaded]  = rel;
                job_dl[jobs_loaded]   = dl;
                job_left[jobs_loaded] = units;
                jobs_loaded++;
            end
            return 1'b0;
        end
        if (today >= MAX_DAYS) begin
            res.day     = 8'(MAX_DAYS);
            res.outcome = sched_failed ? edfs_pkg::OUTCOME_FAILED : edfs_pkg::OUTCOME_IDLE;
            return 1'b1;
        end
        today++;
        res.day = 8'(today);
        if (sched_failed) begin
            res.outcome = edfs_pkg::OUTCOME_FAILED;
            return 1'b1;
        end
        for (k = 0; k < jobs_loaded; k++) begin
            if (int'(job_dl[k]) == today) begin
                if (due_any < 0) due_any = k;
                if (job_left[k] != 0 && due_left < 0) due_left = k;
            end else if (int'(job_dl[k]) > today && int'(job_rel[k]) <= today
                         && job_left[k] != 0) begin
                if (best < 0 || job_dl[k] < job_dl[best]) best = k;
            end
        end
        if (due_left >= 0) begin
            sched_failed = 1'b1;
            res.outcome  = edfs_pkg::OUTCOME_FAILED;
            res.job      = 7'(due_left + 1);
        end else if (due_any >= 0) begin
            res.outcome = edfs_pkg::OUTCOME_DEADLINE;
            res.job     = 7'(due_any + 1);
        end else if (best >= 0) begin
            job_left[best]--;
            res.outcome = edfs_pkg::OUTCOME_GIVEN;
            res.job     = 7'(best + 1);
        end else begin
            res.outcome = edfs_pkg::OUTCOME_IDLE;
        end
        return 1'b1;
    endfunction

    task automatic send_beat(input bit req, input logic [7:0] rel, input logic [7:0] dl,
                             input logic [6:0] units, input bit typed,
                             input day_result_t want);
        day_result_t got;
        bit          has_result;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, units, dl, rel};
        do @(posedge aclk); while (!s_tready);
        if (req == REQ_TICK || jobs_loaded < MAX_JOBS) items_sent++;
        has_result = schedule_step(req, rel, dl, units, got);
        if (has_result) pending_days.push_back(typed ? want : got);
    endtask

    task automatic pace_sender();
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap        = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_days.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_phase <= '0;
        end else begin
            if (rx_phase == 0) rx_mode <= 2'($urandom_range(0, 3));
            rx_phase <= rx_phase + 1'b1;
            case (rx_mode)
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (rx_phase[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        day_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_days.size() == 0) begin
                report_mismatch("result beat with none expected", m_tdata[7:0], 0);
            end else begin
                want = pending_days.pop_front();
                outcome_seen[m_tuser]++;
                if (m_tdata[7:0] != want.day)
                    report_mismatch("day_number", m_tdata[7:0], want.day);
                if (m_tuser != want.outcome)
                    report_mismatch("outcome", m_tuser, want.outcome);
                if (m_tdata[14:8] != want.job)
                    report_mismatch("job_index", m_tdata[14:8], want.job);
            end
        end
    end

    initial begin
        int         i;
        int         waited;
        int         fail_day;
        int         load_cap;
        bit         fail_plan;
        bit         fail_done;
        bit         drained_mid;
        bit         req;
        logic [7:0] rel;
        logic [7:0] dl;
        logic [6:0] units;

        dir_rows = '{
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b1, '{8'd1, edfs_pkg::OUTCOME_IDLE, 7'd0}},
            '{REQ_LOAD, 8'd0,   8'd4,   7'd1,   1'b0, '0},
            '{REQ_LOAD, 8'd2,   8'd4,   7'd1,   1'b0, '0},
            '{REQ_LOAD, 8'd1,   8'd0,   7'd5,   1'b0, '0},
            '{REQ_LOAD, 8'd1,   8'd255, 7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_LOAD, 8'd255, 8'd255, 7'd127, 1'b0, '0},
            '{REQ_LOAD, 8'd3,   8'd2,   7'd1,   1'b0, '0},
            '{REQ_LOAD, 8'd5,   8'd7,   7'd2,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b1, '{8'd8, edfs_pkg::OUTCOME_IDLE, 7'd0}},
            '{REQ_LOAD, 8'd0,   8'd11,  7'd1,   1'b0, '0},
            '{REQ_LOAD, 8'd0,   8'd11,  7'd1,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0},
            '{REQ_TICK, 8'd0,   8'd0,   7'd0,   1'b0, '0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            send_beat(dir_rows[i].req, dir_rows[i].rel, dir_rows[i].dl, dir_rows[i].units,
                      dir_rows[i].typed, dir_rows[i].want);
            pace_sender();
        end
        drain_results();

        // Jobs are mostly feasible so the schedule runs deep; on some seeds one
        // hopeless job is planted late to reach the sticky failure.
        fail_plan   = 1'($urandom_range(0, 1));
        fail_day    = $urandom_range(90, 115);
        fail_done   = 1'b0;
        drained_mid = 1'b0;
        while (items_sent < ITEMS) begin
            req      = REQ_TICK;
            rel      = 8'($urandom);
            dl       = 8'($urandom);
            units    = 7'($urandom);
            load_cap = (fail_plan && !fail_done) ? MAX_JOBS - 1 : MAX_JOBS;
            if (fail_plan && !fail_done && today >= fail_day) begin
                req       = REQ_LOAD;
                rel       = 8'd0;
                dl        = 8'(today + 2);
                units     = 7'd100;
                fail_done = 1'b1;
            end else if (jobs_loaded < load_cap && today < MAX_DAYS - 10
                         && $urandom_range(0, 9) < 4) begin
                req = REQ_LOAD;
                if ($urandom_range(0, 5) == 0) begin
                    rel   = 8'($urandom_range(0, 255));
                    units = 7'($urandom_range(0, 127));
                    case ($urandom_range(0, 2))
                        0: dl = 8'd0;
                        1: dl = 8'($urandom_range(MAX_DAYS + 1, 255));
                        default: dl = 8'($urandom_range(0, today));
                    endcase
                end else begin
                    units = 7'($urandom_range(1, 3));
                    if ($urandom_range(0, 3) == 0) rel = 8'($urandom_range(0, today));
                    else rel = 8'(today + $urandom_range(0, 4));
                    dl = rel + 8'(units) + 8'($urandom_range(1, 15));
                end
            end else if (jobs_loaded >= MAX_JOBS && $urandom_range(0, 19) == 0) begin
                req = REQ_LOAD;
            end
            send_beat(req, rel, dl, units, 1'b0, '0);
            pace_sender();
            if (!drained_mid && items_sent >= ITEMS / 2) begin
                drain_results();
                drained_mid = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_days.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        while (pending_days.size() != 0) begin
            report_mismatch("result never arrived for day", 0, pending_days[0].day);
            void'(pending_days.pop_front());
        end
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Covered %0d beats: %0d jobs stored, schedule reached day %0d%s.",
                 items_sent, jobs_loaded, today, sched_failed ? " after a failure" : "");
        $display("Results seen: %0d idle, %0d given, %0d deadline, %0d failed; %0d errors.",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- edf_unit_task_scheduler_core.f -----
src/edfs_pkg.sv
src/edfs_ram.sv
src/edfs_ctrl.sv
src/edfs_datapath.sv
src/edf_unit_task_scheduler_core.sv
tb/sv/testbench.sv
